// ----- rtl/isotp_pkg.sv -----
// ----------------------------------------------------------------------------
// ISO-TP reassembler package
// Frame types, result kinds, error codes and field widths shared by the core.
// ----------------------------------------------------------------------------
package isotp_pkg;

  localparam int unsigned IdWidth   = 29;
  localparam int unsigned RemWidth  = 12;
  localparam int unsigned NumBytes  = 7;
  localparam int unsigned CntWidth  = 3;
  localparam int unsigned InWidth   = 104;
  localparam int unsigned OutWidth  = 16;

  localparam logic [3:0] FrameSingle      = 4'd0;
  localparam logic [3:0] FrameFirst       = 4'd1;
  localparam logic [3:0] FrameConsecutive = 4'd2;

  localparam logic [3:0] MaxFrameLength = 4'd8;
  localparam logic [RemWidth-1:0] FirstFrameBytes = 12'd6;

  typedef enum logic [1:0] {
    KindPayload     = 2'd0,
    KindFlowControl = 2'd1,
    KindError       = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ErrEmpty    = 2'd0,
    ErrType     = 2'd1,
    ErrSequence = 2'd2,
    ErrLength   = 2'd3
  } err_e;

  typedef struct packed {
    logic [CntWidth-1:0] cnt;
    logic                fc_last;
    logic                err;
    err_e                code;
    logic                eom;
  } plan_t;

endpackage

// ----- rtl/isotp_frame_reassembler_core.sv -----
// ----------------------------------------------------------------------------
// ISO-TP frame reassembler core
// Receives CAN frames, checks them against the ISO-TP receive protocol and
// emits payload bytes, flow-control requests and error reports.
// ----------------------------------------------------------------------------
// A frame's first result passes the result buffer, then the output register.
// Throughput: one result per cycle unless m_axis_tready stalls; up to seven
// results per frame; the next frame is taken once the buffer empties or its
// last result enters the output register, which the buffer feeds one per cycle.
// Reset returns the block to idle with the expected sequence number at one,
// empties the result buffer and sets accept_id to zero.
module isotp_frame_reassembler_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [isotp_pkg::IdWidth-1:0]   cfg_data_i,     // accept_id
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // frame_id[28:0], frame_length[32:29], data0..data7[96:33], zero fill
  input  logic [isotp_pkg::InWidth-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // payload_byte[7:0], end_of_message[8], error_code[10:9], zero fill
  output logic [isotp_pkg::OutWidth-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,
  output logic [1:0]                      m_axis_tuser    // kind[1:0]
);
  import isotp_pkg::*;

  logic [IdWidth-1:0]  accept_id_q;
  logic                receiving_q, receiving_d;
  logic [RemWidth-1:0] rem_q, rem_d;
  logic [3:0]          seq_q, seq_d;

  logic                plan_valid_q, plan_valid_d;
  plan_t               plan_q, plan_d;
  logic [7:0]          bytes_q [NumBytes];
  logic [7:0]          bytes_d [NumBytes];
  logic                plan_load;

  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_eom_q;
  err_e                out_code_q;
  logic                out_last_q;
  kind_e               out_kind_q;

  logic [IdWidth-1:0]  in_id;
  logic [3:0]          in_len;
  logic [7:0]          d [8];
  logic [3:0]          in_type;
  logic [3:0]          len_sat;
  logic [CntWidth-1:0] n_avail;
  logic [RemWidth-1:0] total;
  logic [CntWidth-1:0] n_cf;
  logic [RemWidth-1:0] rem_after;

  logic                in_fire;
  logic                out_load;
  logic                plan_last;
  logic                res_last;
  kind_e               res_kind;

  always_comb begin
    in_id  = s_axis_tdata[28:0];
    in_len = s_axis_tdata[32:29];
    for (int i = 0; i < 8; i++) begin
      d[i] = s_axis_tdata[33 + 8*i +: 8];
    end
    in_type = d[0][7:4];
    len_sat = (in_len > MaxFrameLength) ? MaxFrameLength : in_len;
    n_avail = CntWidth'(len_sat - 4'd1);
    total   = {d[0][3:0], d[1]};
    if ({{(RemWidth-CntWidth){1'b0}}, n_avail} > rem_q) begin
      n_cf = rem_q[CntWidth-1:0];
    end else begin
      n_cf = n_avail;
    end
    rem_after = rem_q - {{(RemWidth-CntWidth){1'b0}}, n_cf};
  end

  assign plan_last     = (plan_q.cnt == CntWidth'(1));
  assign out_load      = plan_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !plan_valid_q || (out_load && plan_last);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    receiving_d = receiving_q;
    rem_d       = rem_q;
    seq_d       = seq_q;
    plan_load   = 1'b0;
    plan_d      = plan_q;
    for (int i = 0; i < NumBytes; i++) begin
      bytes_d[i] = d[i + 1];
    end
    plan_d.fc_last = 1'b0;
    plan_d.err     = 1'b0;
    plan_d.code    = ErrEmpty;
    plan_d.eom     = 1'b0;
    plan_d.cnt     = n_avail;

    if (in_fire && (in_id == accept_id_q)) begin
      if (in_len == 4'd0) begin
        plan_load   = 1'b1;
        plan_d.err  = 1'b1;
        plan_d.code = ErrEmpty;
      end else if (!receiving_q) begin
        if (in_type == FrameSingle) begin
          plan_load  = (n_avail != '0);
          plan_d.eom = 1'b1;
        end else if (in_type == FrameFirst) begin
          if (total <= FirstFrameBytes) begin
            plan_load   = 1'b1;
            plan_d.err  = 1'b1;
            plan_d.code = ErrLength;
          end else begin
            plan_load      = 1'b1;
            plan_d.cnt     = CntWidth'(NumBytes);
            plan_d.fc_last = 1'b1;
            for (int i = 0; i < NumBytes - 1; i++) begin
              bytes_d[i] = d[i + 2];
            end
            receiving_d = 1'b1;
            rem_d       = total - FirstFrameBytes;
            seq_d       = 4'd1;
          end
        end else begin
          plan_load   = 1'b1;
          plan_d.err  = 1'b1;
          plan_d.code = ErrType;
        end
      end else begin
        if (in_type != FrameConsecutive) begin
          plan_load   = 1'b1;
          plan_d.err  = 1'b1;
          plan_d.code = ErrType;
        end else if (d[0][3:0] != seq_q) begin
          plan_load   = 1'b1;
          plan_d.err  = 1'b1;
          plan_d.code = ErrSequence;
        end else begin
          seq_d      = seq_q + 4'd1;
          rem_d      = rem_after;
          plan_load  = (n_cf != '0);
          plan_d.cnt = n_cf;
          plan_d.eom = (rem_after == '0);
          if (rem_after == '0) begin
            receiving_d = 1'b0;
            seq_d       = 4'd1;
          end
        end
      end
      if (plan_d.err) begin
        plan_d.cnt  = CntWidth'(1);
        receiving_d = 1'b0;
        rem_d       = '0;
        seq_d       = 4'd1;
      end
    end

    if (!plan_load) begin
      plan_d = plan_q;
      for (int i = 0; i < NumBytes; i++) begin
        bytes_d[i] = bytes_q[i];
      end
      if (out_load) begin
        plan_d.cnt = plan_q.cnt - CntWidth'(1);
        for (int i = 0; i < NumBytes - 1; i++) begin
          bytes_d[i] = bytes_q[i + 1];
        end
      end
    end

    plan_valid_d = plan_valid_q;
    if (out_load && plan_last) begin
      plan_valid_d = 1'b0;
    end
    if (plan_load) begin
      plan_valid_d = 1'b1;
    end
  end

  always_comb begin
    res_last = plan_last;
    if (plan_q.err) begin
      res_kind = KindError;
    end else if (res_last && plan_q.fc_last) begin
      res_kind = KindFlowControl;
    end else begin
      res_kind = KindPayload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_id_q  <= '0;
      receiving_q  <= 1'b0;
      rem_q        <= '0;
      seq_q        <= 4'd1;
      plan_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        accept_id_q <= cfg_data_i;
      end
      receiving_q  <= receiving_d;
      rem_q        <= rem_d;
      seq_q        <= seq_d;
      plan_valid_q <= plan_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    plan_q <= plan_d;
    for (int i = 0; i < NumBytes; i++) begin
      bytes_q[i] <= bytes_d[i];
    end
    if (out_load) begin
      out_kind_q <= res_kind;
      out_byte_q <= (res_kind == KindPayload) ? bytes_q[0] : 8'd0;
      out_eom_q  <= (res_kind == KindPayload) && res_last && plan_q.eom;
      out_code_q <= plan_q.err ? plan_q.code : ErrEmpty;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_code_q, out_eom_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_kind_q;

endmodule
